// File: rtl/qpm_pkg.sv
`timescale 1ns / 1ps

package qpm_pkg;

    // Number formats.
    localparam int FRACTION_BITS = 16;
    localparam int GAIN_SHIFT    = 12;
    localparam int Q30_SHIFT     = 30 - FRACTION_BITS;
    localparam int ATAN_LEN      = 24;

    // Datapath widths.
    localparam int MUL_A_W   = 40;
    localparam int MUL_B_W   = 24;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int DIV_W     = 48;
    localparam int DEN_W     = 10;
    localparam int RADIX_BITS = 4;
    localparam int CORDIC_W  = 34;
    localparam int ROTOR_W   = 26;

    // Fixed constants, in Q30 and in the working format with FRACTION_BITS fraction bits.
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint PI_F        = (PI_Q30 + (64'sd1 <<< (Q30_SHIFT - 1))) >>> Q30_SHIFT;
    localparam longint G_F         = ((64'sd981 <<< FRACTION_BITS) + 64'sd50) / 64'sd100;
    localparam longint ROTOR_MAX   = 64'sd1000 <<< FRACTION_BITS;
    localparam longint ONE_F       = 64'sd1 <<< FRACTION_BITS;

    // Divisors used for rounding divisions, with half of each.
    localparam logic [DEN_W-1:0] DEN_AXIS      = 10'd100;
    localparam logic [DEN_W-1:0] DEN_AXIS_HALF = 10'd50;
    localparam logic [DEN_W-1:0] DEN_TILT      = 10'd981;
    localparam logic [DEN_W-1:0] DEN_TILT_HALF = 10'd490;

    // Operation codes.
    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_TAKEOFF = 3'd1,
        OP_LAND    = 3'd2,
        OP_HOVER   = 3'd3,
        OP_MOVE    = 3'd4
    } t_op;

    // Configuration register indexes.
    localparam logic [2:0] CFG_GAINS_X   = 3'd0;
    localparam logic [2:0] CFG_GAINS_Y   = 3'd1;
    localparam logic [2:0] CFG_GAINS_Z   = 3'd2;
    localparam logic [2:0] CFG_TAKEOFF   = 3'd3;
    localparam logic [2:0] CFG_LANDING   = 3'd4;
    localparam logic [2:0] CFG_THRESHOLD = 3'd5;
    localparam logic [2:0] CFG_INT_LIMIT = 3'd6;
    localparam logic [2:0] CFG_MASS      = 3'd7;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_ERR,
        S_IDIV,
        S_PID0,
        S_PID1,
        S_PID2,
        S_PID3,
        S_TILT0,
        S_TILT1,
        S_TILT2,
        S_THR0,
        S_THR1,
        S_QUAT0,
        S_QUAT1,
        S_QUAT2,
        S_QUAT3,
        S_QUAT4,
        S_CORD0,
        S_CORD1,
        S_WRAP,
        S_RATE,
        S_OUT
    } t_state;

    // Arctangent of 2^-i in Q30.
    function automatic logic signed [CORDIC_W-1:0] atan_entry(input logic [4:0] idx);
        logic signed [CORDIC_W-1:0] v;
        begin
            unique case (idx)
                5'd0:  v = 34'sd843314857;
                5'd1:  v = 34'sd497837829;
                5'd2:  v = 34'sd263043837;
                5'd3:  v = 34'sd133525159;
                5'd4:  v = 34'sd67021687;
                5'd5:  v = 34'sd33543516;
                5'd6:  v = 34'sd16775851;
                5'd7:  v = 34'sd8388437;
                5'd8:  v = 34'sd4194283;
                5'd9:  v = 34'sd2097149;
                5'd10: v = 34'sd1048576;
                5'd11: v = 34'sd524288;
                5'd12: v = 34'sd262144;
                5'd13: v = 34'sd131072;
                5'd14: v = 34'sd65536;
                5'd15: v = 34'sd32768;
                5'd16: v = 34'sd16384;
                5'd17: v = 34'sd8192;
                5'd18: v = 34'sd4096;
                5'd19: v = 34'sd2048;
                5'd20: v = 34'sd1024;
                5'd21: v = 34'sd512;
                5'd22: v = 34'sd256;
                5'd23: v = 34'sd128;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

// File: rtl/qpm_mul.sv
`timescale 1ns / 1ps

module qpm_mul (
    input  logic                                  i_clk,
    input  logic signed [qpm_pkg::MUL_A_W-1:0]    i_a,
    input  logic signed [qpm_pkg::MUL_B_W-1:0]    i_b,
    output logic signed [qpm_pkg::PROD_W-1:0]     o_prod
);
    import qpm_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    // One signed product per cycle, registered.
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// File: rtl/qpm_div.sv
`timescale 1ns / 1ps

module qpm_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [qpm_pkg::DIV_W-1:0]    i_num,
    input  logic        [qpm_pkg::DEN_W-1:0]    i_den,
    input  logic        [qpm_pkg::DEN_W-1:0]    i_half,
    output logic                                o_done,
    output logic signed [qpm_pkg::DIV_W-1:0]    o_quot
);
    import qpm_pkg::*;

    localparam int DIV_STEPS = DIV_W / RADIX_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    logic [DIV_W-1:0]        r_work;
    logic [DEN_W-1:0]        r_rem;
    logic [DEN_W-1:0]        r_den;
    logic                    r_neg;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_busy;
    logic                    r_done;
    logic signed [DIV_W-1:0] r_quot;

    logic [DIV_W-1:0]        n_work;
    logic [DEN_W-1:0]        n_rem;
    logic [DIV_W-1:0]        w_mag;
    logic [DEN_W:0]          w_trial;

    // Magnitude plus half the divisor gives rounding to nearest, ties away from zero.
    assign w_mag = (i_num < 0 ? DIV_W'(-i_num) : DIV_W'(i_num)) + DIV_W'(i_half);

    // Restoring division, RADIX_BITS quotient bits per cycle on a narrow remainder.
    always_comb begin
        n_work = r_work;
        n_rem  = r_rem;
        w_trial = '0;
        for (int k = 0; k < RADIX_BITS; k++) begin
            w_trial = {n_rem, n_work[DIV_W-1]};
            n_work  = {n_work[DIV_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_den}) begin
                n_rem     = DEN_W'(w_trial - {1'b0, r_den});
                n_work[0] = 1'b1;
            end else begin
                n_rem = w_trial[DEN_W-1:0];
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= w_mag;
            r_rem  <= '0;
            r_den  <= i_den;
            r_neg  <= (i_num < 0);
        end else if (r_busy) begin
            r_work <= n_work;
            r_rem  <= n_rem;
            if (r_cnt == '0) begin
                r_quot <= r_neg ? -$signed(n_work) : $signed(n_work);
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: rtl/qpm_cordic.sv
`timescale 1ns / 1ps

module qpm_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [31:0]                     i_y,
    input  logic signed [31:0]                     i_x,
    output logic                                   o_done,
    output logic signed [qpm_pkg::CORDIC_W-1:0]    o_angle
);
    import qpm_pkg::*;

    localparam int NSTEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    localparam int CNT_W  = $clog2(NSTEPS);

    logic signed [CORDIC_W-1:0] r_x;
    logic signed [CORDIC_W-1:0] r_y;
    logic signed [CORDIC_W-1:0] r_z;
    logic [CNT_W-1:0]           r_i;
    logic                       r_busy;
    logic                       r_done;

    logic signed [CORDIC_W-1:0] w_x0;
    logic signed [CORDIC_W-1:0] w_y0;
    logic signed [CORDIC_W-1:0] w_xs;
    logic signed [CORDIC_W-1:0] w_ys;
    logic signed [CORDIC_W-1:0] w_atan;
    logic                       w_zero;

    assign w_x0   = CORDIC_W'(i_x);
    assign w_y0   = CORDIC_W'(i_y);
    assign w_zero = (i_x == '0) && (i_y == '0);
    assign w_xs   = r_x >>> r_i;
    assign w_ys   = r_y >>> r_i;
    assign w_atan = atan_entry(5'(r_i));

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_i <= '0;
                if (w_zero) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == CNT_W'(NSTEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Vector rotation: pre-rotate into the right half plane, then one step a cycle.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            if (w_zero) begin
                r_x <= '0;
                r_y <= '0;
                r_z <= '0;
            end else if (w_x0 < 0) begin
                if (w_y0 >= 0) begin
                    r_x <= w_y0;
                    r_y <= -w_x0;
                    r_z <= CORDIC_W'(HALF_PI_Q30);
                end else begin
                    r_x <= -w_y0;
                    r_y <= w_x0;
                    r_z <= -CORDIC_W'(HALF_PI_Q30);
                end
            end else begin
                r_x <= w_x0;
                r_y <= w_y0;
                r_z <= '0;
            end
        end else if (r_busy) begin
            if (r_y >= 0) begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_atan;
            end else begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_atan;
            end
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_z;

endmodule

// File: rtl/quadrotor_pid_mixer_unit.sv
// Sequence: a control tick passes through the shared multiplier, the divider used
// five times and the CORDIC loop; a landed tick goes straight to the output state,
// and commands update the controller state while the sequencer stays idle.
// Throughput: one item at a time; the input is ready only while the sequencer idles.
// Reset: synchronous, active low; restores configuration defaults, targets and integrals.
`timescale 1ns / 1ps

module quadrotor_pid_mixer_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [47:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_operation,
    input  logic signed [31:0] i_x_value,
    input  logic signed [31:0] i_y_value,
    input  logic signed [31:0] i_z_value,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic signed [31:0] i_vel_z,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    input  logic signed [20:0] i_yaw_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [25:0]        o_rotor_front_left,
    output logic [25:0]        o_rotor_front_right,
    output logic [25:0]        o_rotor_back_left,
    output logic [25:0]        o_rotor_back_right,
    output logic               o_stopped
);
    import qpm_pkg::*;

    localparam int MIX_W = 50;
    localparam logic signed [MIX_W-1:0] ROTOR_MAX_L = MIX_W'(ROTOR_MAX);
    localparam logic signed [22:0]      PI_L        = 23'(PI_F);
    localparam logic signed [22:0]      TWO_PI_L    = 23'(2 * PI_F);

    // Configuration registers.
    logic [47:0] r_gain [3];
    logic [22:0] r_takeoff;
    logic [22:0] r_landh;
    logic [22:0] r_thresh;
    logic [22:0] r_lim;
    logic [22:0] r_mass;

    // Controller state.
    logic signed [31:0] r_tgt [3];
    logic signed [20:0] r_heading;
    logic signed [23:0] r_integ [3];
    logic signed [31:0] r_last [3];
    logic               r_flying;

    // Sequencer and working registers.
    t_state             r_state;
    t_state             n_state;
    logic [1:0]         r_axis;
    logic               r_landed;
    logic signed [31:0] r_pos [3];
    logic signed [31:0] r_vel [3];
    logic signed [15:0] r_quat [4];
    logic signed [32:0] r_err;
    logic signed [PROD_W-1:0] r_acc;
    logic signed [39:0] r_axacc [3];
    logic signed [39:0] r_tilt [2];
    logic signed [47:0] r_thrust;
    logic signed [31:0] r_s;
    logic signed [31:0] r_c;
    logic signed [22:0] r_e;
    logic signed [39:0] r_rate;

    // Output register.
    logic               r_out_valid;
    logic [ROTOR_W-1:0] r_rotor [4];
    logic               r_stopped;

    // Shared unit connections.
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic                      w_div_start;
    logic signed [DIV_W-1:0]   w_div_num;
    logic [DEN_W-1:0]          w_div_den;
    logic [DEN_W-1:0]          w_div_half;
    logic                      w_div_done;
    logic signed [DIV_W-1:0]   w_div_quot;
    logic                      w_cord_start;
    logic                      w_cord_done;
    logic signed [CORDIC_W-1:0] w_angle;

    // Combinational helpers.
    logic                      w_accept;
    logic                      w_load;
    logic [47:0]               w_gain;
    logic signed [32:0]        w_diff;
    logic signed [33:0]        w_isum;
    logic signed [33:0]        w_ilim;
    logic signed [PROD_W-1:0]  w_pid;
    logic signed [PROD_W-1:0]  w_quad;
    logic signed [CORDIC_W-1:0] w_yaw_full;
    logic signed [22:0]        w_yaw;
    logic signed [MIX_W-1:0]   w_t;
    logic signed [MIX_W-1:0]   w_r;
    logic signed [MIX_W-1:0]   w_p;
    logic signed [MIX_W-1:0]   w_w;
    logic signed [MIX_W-1:0]   w_mix [4];

    function automatic logic [ROTOR_W-1:0] clamp_rotor(input logic signed [MIX_W-1:0] v);
        logic [ROTOR_W-1:0] res;
        begin
            if (v < 0) begin
                res = '0;
            end else if (v > ROTOR_MAX_L) begin
                res = ROTOR_MAX_L[ROTOR_W-1:0];
            end else begin
                res = v[ROTOR_W-1:0];
            end
            return res;
        end
    endfunction

    // Shared arithmetic units.
    qpm_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    qpm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .i_half  (w_div_half),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    qpm_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cord_start),
        .i_y     (r_s),
        .i_x     (r_c),
        .o_done  (w_cord_done),
        .o_angle (w_angle)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_load     = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
    assign w_gain     = r_gain[r_axis];

    // Arithmetic shared by several states.
    assign w_diff = 33'(r_tgt[r_axis]) - 33'(r_pos[r_axis]);
    assign w_isum = 34'(r_integ[r_axis]) + w_div_quot[33:0];
    assign w_ilim = $signed({11'd0, r_lim});
    assign w_pid  = (r_acc - w_prod + (PROD_W'(1) <<< (GAIN_SHIFT - 1))) >>> GAIN_SHIFT;
    assign w_quad = r_acc + w_prod;
    assign w_yaw_full = (w_angle + (CORDIC_W'(1) <<< (Q30_SHIFT - 1))) >>> Q30_SHIFT;
    assign w_yaw      = w_yaw_full[22:0];

    // Mixer sums.
    assign w_t = MIX_W'(r_thrust);
    assign w_r = MIX_W'(r_tilt[0]);
    assign w_p = MIX_W'(r_tilt[1]);
    assign w_w = MIX_W'(r_rate);
    assign w_mix[0] = w_t + w_r + w_p - w_w;
    assign w_mix[1] = w_t - w_r + w_p + w_w;
    assign w_mix[2] = w_t + w_r - w_p + w_w;
    assign w_mix[3] = w_t - w_r - w_p - w_w;

    // Sequencer: next state and shared unit operands.
    always_comb begin
        n_state      = r_state;
        w_mul_a      = '0;
        w_mul_b      = '0;
        w_div_start  = 1'b0;
        w_div_num    = '0;
        w_div_den    = DEN_AXIS;
        w_div_half   = DEN_AXIS_HALF;
        w_cord_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_operation == OP_TICK)) begin
                    if (!r_flying && (i_z_value < $signed({9'd0, r_thresh}))) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_ERR;
                    end
                end
            end
            S_ERR: begin
                w_div_start = 1'b1;
                w_div_num   = DIV_W'(w_diff);
                n_state     = S_IDIV;
            end
            S_IDIV: begin
                if (w_div_done) begin
                    n_state = S_PID0;
                end
            end
            S_PID0: begin
                w_mul_a = MUL_A_W'(r_err);
                w_mul_b = $signed({8'd0, w_gain[47:32]});
                n_state = S_PID1;
            end
            S_PID1: begin
                w_mul_a = MUL_A_W'(r_integ[r_axis]);
                w_mul_b = $signed({8'd0, w_gain[31:16]});
                n_state = S_PID2;
            end
            S_PID2: begin
                w_mul_a = MUL_A_W'(r_vel[r_axis]);
                w_mul_b = $signed({8'd0, w_gain[15:0]});
                n_state = S_PID3;
            end
            S_PID3: begin
                n_state = (r_axis == 2'd2) ? S_TILT0 : S_ERR;
            end
            S_TILT0: begin
                w_mul_a = r_axacc[r_axis];
                w_mul_b = 24'sd100;
                n_state = S_TILT1;
            end
            S_TILT1: begin
                w_div_start = 1'b1;
                w_div_num   = w_prod[DIV_W-1:0];
                w_div_den   = DEN_TILT;
                w_div_half  = DEN_TILT_HALF;
                n_state     = S_TILT2;
            end
            S_TILT2: begin
                if (w_div_done) begin
                    n_state = (r_axis == 2'd1) ? S_THR0 : S_TILT0;
                end
            end
            S_THR0: begin
                w_mul_a = r_axacc[2] + MUL_A_W'(G_F);
                w_mul_b = $signed({1'b0, r_mass});
                n_state = S_THR1;
            end
            S_THR1: begin
                n_state = S_QUAT0;
            end
            S_QUAT0: begin
                w_mul_a = MUL_A_W'(r_quat[0]);
                w_mul_b = MUL_B_W'(r_quat[3]);
                n_state = S_QUAT1;
            end
            S_QUAT1: begin
                w_mul_a = MUL_A_W'(r_quat[1]);
                w_mul_b = MUL_B_W'(r_quat[2]);
                n_state = S_QUAT2;
            end
            S_QUAT2: begin
                w_mul_a = MUL_A_W'(r_quat[2]);
                w_mul_b = MUL_B_W'(r_quat[2]);
                n_state = S_QUAT3;
            end
            S_QUAT3: begin
                w_mul_a = MUL_A_W'(r_quat[3]);
                w_mul_b = MUL_B_W'(r_quat[3]);
                n_state = S_QUAT4;
            end
            S_QUAT4: begin
                n_state = S_CORD0;
            end
            S_CORD0: begin
                w_cord_start = 1'b1;
                n_state      = S_CORD1;
            end
            S_CORD1: begin
                if (w_cord_done) begin
                    n_state = S_WRAP;
                end
            end
            S_WRAP: begin
                w_mul_a = MUL_A_W'(r_e);
                w_mul_b = $signed({8'd0, r_gain[2][47:32]});
                if ((r_e <= PI_L) && (r_e >= -PI_L)) begin
                    n_state = S_RATE;
                end
            end
            S_RATE: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes and controller state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain[0] <= 48'd8796093023027;
            r_gain[1] <= 48'd8796093023027;
            r_gain[2] <= 48'd17592212916224;
            r_takeoff <= 23'd98304;
            r_landh   <= 23'd6554;
            r_thresh  <= 23'd13107;
            r_lim     <= 23'd327680;
            r_mass    <= 23'd163840;
            r_tgt[0]  <= '0;
            r_tgt[1]  <= '0;
            r_tgt[2]  <= 32'(ONE_F);
            r_heading <= '0;
            for (int i = 0; i < 3; i++) begin
                r_integ[i] <= '0;
                r_last[i]  <= '0;
            end
            r_flying  <= 1'b0;
            r_landed  <= 1'b0;
            r_axis    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_GAINS_X:   r_gain[0] <= i_cfg_data;
                    CFG_GAINS_Y:   r_gain[1] <= i_cfg_data;
                    CFG_GAINS_Z:   r_gain[2] <= i_cfg_data;
                    CFG_TAKEOFF:   r_takeoff <= i_cfg_data[22:0];
                    CFG_LANDING:   r_landh   <= i_cfg_data[22:0];
                    CFG_THRESHOLD: r_thresh  <= i_cfg_data[22:0];
                    CFG_INT_LIMIT: r_lim     <= i_cfg_data[22:0];
                    CFG_MASS:      r_mass    <= i_cfg_data[22:0];
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_axis <= '0;
                priority case (i_operation)
                    OP_TICK: begin
                        r_last[0] <= i_x_value;
                        r_last[1] <= i_y_value;
                        r_last[2] <= i_z_value;
                        r_landed  <= !r_flying &&
                                     (i_z_value < $signed({9'd0, r_thresh}));
                    end
                    OP_TAKEOFF: begin
                        r_tgt[2] <= $signed({9'd0, r_takeoff});
                        r_flying <= 1'b1;
                    end
                    OP_LAND: begin
                        r_tgt[2] <= $signed({9'd0, r_landh});
                        r_flying <= 1'b0;
                    end
                    OP_HOVER: begin
                        for (int i = 0; i < 3; i++) begin
                            r_tgt[i] <= r_last[i];
                        end
                    end
                    OP_MOVE: begin
                        r_tgt[0]  <= i_x_value;
                        r_tgt[1]  <= i_y_value;
                        r_tgt[2]  <= i_z_value;
                        r_heading <= i_yaw_value;
                    end
                    default: ;
                endcase
            end
            // Integral update with a symmetric clamp.
            if ((r_state == S_IDIV) && w_div_done) begin
                if (w_isum > w_ilim) begin
                    r_integ[r_axis] <= w_ilim[23:0];
                end else if (w_isum < -w_ilim) begin
                    r_integ[r_axis] <= 24'(-w_ilim);
                end else begin
                    r_integ[r_axis] <= w_isum[23:0];
                end
            end
            // Axis counter through the PID and tilt passes.
            if (r_state == S_PID3) begin
                r_axis <= (r_axis == 2'd2) ? 2'd0 : r_axis + 1'b1;
            end
            if ((r_state == S_TILT2) && w_div_done) begin
                r_axis <= r_axis + 1'b1;
            end
        end
    end

    // Working datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pos[0]  <= i_x_value;
            r_pos[1]  <= i_y_value;
            r_pos[2]  <= i_z_value;
            r_vel[0]  <= i_vel_x;
            r_vel[1]  <= i_vel_y;
            r_vel[2]  <= i_vel_z;
            r_quat[0] <= i_quat_w;
            r_quat[1] <= i_quat_x;
            r_quat[2] <= i_quat_y;
            r_quat[3] <= i_quat_z;
        end
        unique case (r_state)
            S_ERR: r_err <= w_diff;
            S_PID1: r_acc <= w_prod;
            S_PID2: r_acc <= r_acc + w_prod;
            S_PID3: r_axacc[r_axis] <= w_pid[39:0];
            S_TILT2: begin
                if (w_div_done) begin
                    r_tilt[r_axis[0]] <= w_div_quot[39:0];
                end
            end
            S_THR1: begin
                r_thrust <= 48'((w_prod + (PROD_W'(1) <<< (FRACTION_BITS - 1)))
                                >>> FRACTION_BITS);
            end
            S_QUAT1: r_acc <= w_prod;
            S_QUAT2: r_s <= 32'(w_quad <<< 1);
            S_QUAT3: r_acc <= w_prod;
            S_QUAT4: r_c <= 32'((PROD_W'(1) <<< 28) - (w_quad <<< 1));
            S_CORD1: begin
                if (w_cord_done) begin
                    r_e <= 23'(r_heading) - w_yaw;
                end
            end
            S_WRAP: begin
                if (r_e > PI_L) begin
                    r_e <= r_e - TWO_PI_L;
                end else if (r_e < -PI_L) begin
                    r_e <= r_e + TWO_PI_L;
                end
            end
            S_RATE: begin
                r_rate <= 40'((w_prod + (PROD_W'(1) <<< (GAIN_SHIFT - 1))) >>> GAIN_SHIFT);
            end
            default: ;
        endcase
    end

    // Result register: loaded when the previous result has been taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_stopped <= r_landed;
            for (int i = 0; i < 4; i++) begin
                r_rotor[i] <= r_landed ? '0 : clamp_rotor(w_mix[i]);
            end
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_rotor_front_left  = r_rotor[0];
    assign o_rotor_front_right = r_rotor[1];
    assign o_rotor_back_left   = r_rotor[2];
    assign o_rotor_back_right  = r_rotor[3];
    assign o_stopped           = r_stopped;

`ifndef SYNTHESIS
    // A stopped result carries all rotors at zero.
    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_stopped) |-> (o_rotor_front_left == '0 &&
        o_rotor_front_right == '0 && o_rotor_back_left == '0 && o_rotor_back_right == '0))
        else $error("stopped result with a rotor running");

    // Every rotor speed stays within the clamp.
    a_rotor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_rotor_front_left <= ROTOR_MAX_L[ROTOR_W-1:0] &&
        o_rotor_front_right <= ROTOR_MAX_L[ROTOR_W-1:0] &&
        o_rotor_back_left <= ROTOR_MAX_L[ROTOR_W-1:0] &&
        o_rotor_back_right <= ROTOR_MAX_L[ROTOR_W-1:0]))
        else $error("rotor speed beyond clamp");

    // A new result only appears from the output state.
    a_load_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result raised outside the output state");
`endif

endmodule
